[rtl/sdi_pkg.sv]
package sdi_pkg;

  localparam int unsigned MAX_BINS_DEF    = 4096;
  localparam int unsigned TAPER_DEPTH_DEF = 256;
  localparam int unsigned SAMPLE_WIDTH    = 24;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned BIN_REG_W    = 13;
  localparam int unsigned OMEGA_STEP_W = 32;
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned TADDR_W      = 8;
  localparam int unsigned BIN_NUM_W    = 12;
  localparam int unsigned RESULT_W     = 32;
  localparam int unsigned FRAC_W       = 20;
  localparam int unsigned TAPER_FRAC_W = 15;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << TAPER_FRAC_W;
  localparam logic [RESULT_W-1:0] POS_LIM    = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic [RESULT_W-1:0] NEG_MAG    = {1'b1, {(RESULT_W-1){1'b0}}};

  localparam logic [CMD_W-1:0] CMD_PROCESS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_LOWER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_UPPER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT_BIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PASS_BIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PASS_BIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT_BIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_STEP     = 3'd5;

  typedef struct packed {
    logic        [CMD_W-1:0]        command;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic        [TADDR_W-1:0]      taper_addr;
    logic        [WEIGHT_W-1:0]     taper_weight;
    logic                           last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0]  result_re;
    logic signed [RESULT_W-1:0]  result_im;
    logic        [BIN_NUM_W-1:0] bin_number;
    logic                        saturated;
    logic                        divide_by_zero;
    logic                        trace_end;
  } out_item_t;

  typedef struct packed {
    logic                    divide;
    logic                    zero;
    logic                    neg;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic                    taper;
    logic [WEIGHT_W-1:0]     weight;
  } lane_op_t;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic                sat;
  } lane_res_t;

endpackage

[rtl/sdi_ram.sv]
module sdi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sdi_lane.sv]
module sdi_lane #(
  parameter int unsigned OMEGA_W = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sdi_pkg::lane_op_t   op_i,
  input  logic [OMEGA_W-1:0]  omega_i,
  input  logic                ack_i,
  output logic                done_o,
  output sdi_pkg::lane_res_t  res_o
);

  localparam int unsigned MAG_W  = sdi_pkg::SAMPLE_WIDTH;
  localparam int unsigned RES_W  = sdi_pkg::RESULT_W;
  localparam int unsigned SPLIT  = 32;
  localparam int unsigned QW     = sdi_pkg::RESULT_W;
  localparam int unsigned QCNT_W = $clog2(QW);
  localparam int unsigned PLO_W  = MAG_W + SPLIT;
  localparam int unsigned PHI_W  = MAG_W + OMEGA_W - SPLIT;
  localparam int unsigned SUM_W  = MAG_W + OMEGA_W + 1;
  localparam int unsigned TW     = SUM_W - sdi_pkg::FRAC_W;
  localparam int unsigned NW     = MAG_W + OMEGA_W + 1;
  localparam int unsigned NHI_W  = NW - QW;
  localparam int unsigned DW     = OMEGA_W + 1;
  localparam int unsigned RW     = OMEGA_W + 2;
  localparam int unsigned CW     = (NHI_W > RW) ? NHI_W : RW;
  localparam int unsigned SATW   = (TW > RES_W + 1) ? TW : RES_W + 1;
  localparam int unsigned TPW    = RES_W + sdi_pkg::WEIGHT_W;

  localparam logic [2:0] L_IDLE    = 3'd0;
  localparam logic [2:0] L_PREP    = 3'd1;
  localparam logic [2:0] L_MUL_HI  = 3'd2;
  localparam logic [2:0] L_MUL_ADD = 3'd3;
  localparam logic [2:0] L_DIV     = 3'd4;
  localparam logic [2:0] L_QSAT    = 3'd5;
  localparam logic [2:0] L_TAPER   = 3'd6;
  localparam logic [2:0] L_DONE    = 3'd7;

  logic [2:0]              state_q, state_d;
  sdi_pkg::lane_op_t       op_q, op_d;
  logic [OMEGA_W-1:0]      omega_q, omega_d;
  logic [PLO_W-1:0]        plo_q, plo_d;
  logic [PHI_W-1:0]        phi_q, phi_d;
  logic [RW-1:0]           rem_q, rem_d;
  logic [QW-1:0]           nlo_q, nlo_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;
  logic [RES_W-1:0]        mag_q, mag_d;
  logic                    sat_q, sat_d;

  logic [NW-1:0]           n_full;
  logic [CW-1:0]           n_hi;
  logic [DW-1:0]           d_val;
  logic                    ovf_div;
  logic [RW-1:0]           rem2;
  logic                    ge;
  logic [RW-1:0]           rem_next;
  logic [SUM_W-1:0]        sum;
  logic [TW-1:0]           t_val;
  logic [TPW-1:0]          tp;
  logic [RES_W-1:0]        tmag;

  function automatic logic [RES_W:0] sat_mag(input logic [SATW-1:0] v, input logic neg);
    logic [SATW-1:0] lim;
    lim = neg ? SATW'(sdi_pkg::NEG_MAG) : SATW'(sdi_pkg::POS_LIM);
    if (v > lim) begin
      sat_mag = {1'b1, lim[RES_W-1:0]};
    end else begin
      sat_mag = {1'b0, v[RES_W-1:0]};
    end
  endfunction

  // N = 2*|x|*2^20 + omega, D = 2*omega; N/D rounds |x|*2^20/omega to nearest
  assign n_full   = (NW'(op_q.mag) << (sdi_pkg::FRAC_W + 1)) + NW'(omega_q);
  assign n_hi     = CW'(n_full[NW-1:QW]);
  assign d_val    = {omega_q, 1'b0};
  assign ovf_div  = n_hi >= CW'(d_val);
  assign rem2     = {rem_q[RW-2:0], nlo_q[QW-1]};
  assign ge       = rem2 >= RW'(d_val);
  assign rem_next = ge ? (rem2 - RW'(d_val)) : rem2;

  assign sum   = SUM_W'(plo_q) + (SUM_W'(phi_q) << SPLIT)
               + (SUM_W'(1) << (sdi_pkg::FRAC_W - 1));
  assign t_val = sum[SUM_W-1:sdi_pkg::FRAC_W];

  assign tp   = (TPW'(mag_q) * TPW'(op_q.weight)) + (TPW'(1) << (sdi_pkg::TAPER_FRAC_W - 1));
  assign tmag = tp[sdi_pkg::TAPER_FRAC_W+RES_W-1:sdi_pkg::TAPER_FRAC_W];

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    omega_d = omega_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    rem_d   = rem_q;
    nlo_d   = nlo_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    sat_d   = sat_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          omega_d = omega_i;
          state_d = L_PREP;
        end
      end
      L_PREP: begin
        sat_d = 1'b0;
        if (op_q.zero) begin
          mag_d   = '0;
          state_d = L_DONE;
        end else if (op_q.divide) begin
          if (ovf_div) begin
            mag_d   = op_q.neg ? sdi_pkg::NEG_MAG : sdi_pkg::POS_LIM;
            sat_d   = 1'b1;
            state_d = L_TAPER;
          end else begin
            rem_d   = n_hi[RW-1:0];
            nlo_d   = n_full[QW-1:0];
            cnt_d   = '1;
            state_d = L_DIV;
          end
        end else begin
          plo_d   = PLO_W'(op_q.mag) * PLO_W'(omega_q[SPLIT-1:0]);
          state_d = L_MUL_HI;
        end
      end
      L_MUL_HI: begin
        phi_d   = PHI_W'(op_q.mag) * PHI_W'(omega_q[OMEGA_W-1:SPLIT]);
        state_d = L_MUL_ADD;
      end
      L_MUL_ADD: begin
        {sat_d, mag_d} = sat_mag(SATW'(t_val), op_q.neg);
        state_d        = L_TAPER;
      end
      L_DIV: begin
        rem_d = rem_next;
        nlo_d = {nlo_q[QW-2:0], 1'b0};
        quo_d = {quo_q[QW-2:0], ge};
        cnt_d = cnt_q - QCNT_W'(1);
        if (cnt_q == '0) begin
          state_d = L_QSAT;
        end
      end
      L_QSAT: begin
        {sat_d, mag_d} = sat_mag(SATW'(quo_q), op_q.neg);
        state_d        = L_TAPER;
      end
      L_TAPER: begin
        if (op_q.taper) begin
          mag_d = tmag;
        end
        state_d = L_DONE;
      end
      L_DONE: begin
        if (ack_i) begin
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    omega_q <= omega_d;
    plo_q   <= plo_d;
    phi_q   <= phi_d;
    rem_q   <= rem_d;
    nlo_q   <= nlo_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    mag_q   <= mag_d;
    sat_q   <= sat_d;
  end

  assign done_o      = (state_q == L_DONE);
  assign res_o.value = op_q.neg ? (RES_W'(0) - mag_q) : mag_q;
  assign res_o.sat   = sat_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == L_DIV) |-> (rem_q < RW'(d_val)))
    else $error("divider remainder not below divisor");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == L_DONE) && !ack_i |=> (state_q == L_DONE) && $stable(res_o))
    else $error("lane result dropped before ack");
`endif

endmodule

[rtl/spectral_derivative_integral_top.sv]
// Spectral derivative / integral. Complex bins enter one transaction at a
// time and are numbered by a running bin counter; each process transaction
// gives one result, taper-table writes give none. A process transaction
// is accepted, then runs in two identical lanes (real and imaginary). In
// derivative mode each lane multiplies the 24-bit sample magnitude by omega
// in two parts, the low 32 bits of omega and then the high bits, and adds
// them with rounding. In integral mode each lane runs a restoring divider
// that produces one quotient bit per cycle for a 32-bit quotient; a lane
// whose quotient overflows skips the divider and saturates. A zeroed bin
// (outside the cuts, or omega zero) skips the arithmetic. A finished result
// waits in the output register while the next transaction is taken; a bin
// only stalls further while that register still holds an untaken result.
// Taper tables power up undefined: load every entry a trace will touch
// before sending bins; there is no clearing pass after reset.
module spectral_derivative_integral_top #(
  parameter int unsigned MAX_BINS    = sdi_pkg::MAX_BINS_DEF,
  parameter int unsigned TAPER_DEPTH = sdi_pkg::TAPER_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sdi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sdi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sdi_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sdi_pkg::out_item_t               out_data_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_BINS);
  localparam int unsigned OMEGA_W = CNT_W + sdi_pkg::OMEGA_STEP_W;
  localparam int unsigned TAW     = $clog2(TAPER_DEPTH);
  localparam int unsigned BRW     = sdi_pkg::BIN_REG_W;
  localparam int unsigned XW      = ((CNT_W > BRW) ? CNT_W : BRW) + 1;
  localparam int unsigned SW      = sdi_pkg::SAMPLE_WIDTH;
  localparam int unsigned WW      = sdi_pkg::WEIGHT_W;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_START = 2'd1;
  localparam logic [1:0] T_RUN   = 2'd2;

  logic [1:0]                  state_q, state_d;

  logic                        integrate_mode_q;
  logic [BRW-1:0]              low_cut_q, low_pass_q, high_pass_q, high_cut_q;
  logic [sdi_pkg::OMEGA_STEP_W-1:0] omega_step_q;

  logic [CNT_W-1:0]            cnt_q;
  logic [CNT_W-1:0]            bin_q;
  logic                        last_q;
  logic signed [SW-1:0]        sre_q, sim_q;
  logic                        in_band_q, lower_q, upper_q;
  logic [OMEGA_W-1:0]          omega_q;
  logic                        dz_q;

  sdi_pkg::out_item_t          out_q;
  logic                        out_valid_q;

  logic                        in_fire, proc_fire, wr_lo, wr_up, wr_ok;
  logic [31:0]                 wa32;
  logic [TAW-1:0]              waddr;
  logic [WW-1:0]               wclamp;
  logic [XW-1:0]               i_x, lc_x, lp_x, hp_x, hc_x;
  logic                        in_band, is_lower, is_upper;
  logic [XW-1:0]               k_lo, k_up, k_lo_c, k_up_c;
  logic [TAW-1:0]              raddr_lo, raddr_up;
  logic [WW-1:0]               rd_lo, rd_up;
  logic                        omega_zero;
  logic                        lane_start;
  sdi_pkg::lane_op_t           re_op, im_op;
  sdi_pkg::lane_res_t          re_res, im_res;
  logic                        re_done, im_done;
  logic                        out_load;
  logic [SW-1:0]               re_mag, im_mag;
  logic [31:0]                 bin32;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integrate_mode_q <= 1'b0;
      low_cut_q        <= '0;
      low_pass_q       <= '0;
      high_pass_q      <= BRW'(4096);
      high_cut_q       <= BRW'(4096);
      omega_step_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdi_pkg::CFG_INTEGRATE_MODE: integrate_mode_q <= cfg_data_i[0];
        sdi_pkg::CFG_LOW_CUT_BIN:    low_cut_q        <= cfg_data_i[BRW-1:0];
        sdi_pkg::CFG_LOW_PASS_BIN:   low_pass_q       <= cfg_data_i[BRW-1:0];
        sdi_pkg::CFG_HIGH_PASS_BIN:  high_pass_q      <= cfg_data_i[BRW-1:0];
        sdi_pkg::CFG_HIGH_CUT_BIN:   high_cut_q       <= cfg_data_i[BRW-1:0];
        sdi_pkg::CFG_OMEGA_STEP:     omega_step_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input side
  assign in_ready_o = (state_q == T_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign proc_fire  = in_fire && (in_data_i.command == sdi_pkg::CMD_PROCESS);
  assign wr_lo      = in_fire && (in_data_i.command == sdi_pkg::CMD_WR_LOWER);
  assign wr_up      = in_fire && (in_data_i.command == sdi_pkg::CMD_WR_UPPER);

  assign wa32   = 32'(in_data_i.taper_addr);
  assign waddr  = wa32[TAW-1:0];
  assign wr_ok  = wa32 < 32'(TAPER_DEPTH);
  assign wclamp = (in_data_i.taper_weight > sdi_pkg::WEIGHT_ONE) ?
                  sdi_pkg::WEIGHT_ONE : in_data_i.taper_weight;

  assign i_x  = XW'(cnt_q);
  assign lc_x = XW'(low_cut_q);
  assign lp_x = XW'(low_pass_q);
  assign hp_x = XW'(high_pass_q);
  assign hc_x = XW'(high_cut_q);

  assign in_band  = (i_x >= lc_x) && (i_x < hc_x);
  assign is_lower = i_x < lp_x;
  assign is_upper = !is_lower && (i_x >= hp_x);

  // upper table runs backward from the high cut
  assign k_lo   = i_x - lc_x;
  assign k_up   = hc_x - XW'(1) - i_x;
  assign k_lo_c = (k_lo >= XW'(TAPER_DEPTH - 1)) ? XW'(TAPER_DEPTH - 1) : k_lo;
  assign k_up_c = (k_up >= XW'(TAPER_DEPTH - 1)) ? XW'(TAPER_DEPTH - 1) : k_up;
  assign raddr_lo = k_lo_c[TAW-1:0];
  assign raddr_up = k_up_c[TAW-1:0];

  sdi_ram #(
    .WIDTH (WW),
    .DEPTH (TAPER_DEPTH)
  ) u_lower_ram (
    .clk_i   (clk_i),
    .en_i    (proc_fire || (wr_lo && wr_ok)),
    .we_i    (wr_lo),
    .addr_i  (wr_lo ? waddr : raddr_lo),
    .wdata_i (wclamp),
    .rdata_o (rd_lo)
  );

  sdi_ram #(
    .WIDTH (WW),
    .DEPTH (TAPER_DEPTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .en_i    (proc_fire || (wr_up && wr_ok)),
    .we_i    (wr_up),
    .addr_i  (wr_up ? waddr : raddr_up),
    .wdata_i (wclamp),
    .rdata_o (rd_up)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (proc_fire) begin
      if (in_data_i.last_bin || (cnt_q == CNT_W'(MAX_BINS - 1))) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      bin_q     <= cnt_q;
      last_q    <= in_data_i.last_bin;
      sre_q     <= in_data_i.sample_re;
      sim_q     <= in_data_i.sample_im;
      in_band_q <= in_band;
      lower_q   <= is_lower;
      upper_q   <= is_upper;
      omega_q   <= OMEGA_W'(cnt_q) * OMEGA_W'(omega_step_q);
    end
    if (state_q == T_START) begin
      dz_q <= in_band_q && omega_zero && integrate_mode_q;
    end
  end

  // lane operands: derivative re = -im*w, im = re*w; integral re = im/w, im = -re/w
  assign omega_zero = (omega_q == '0);
  assign lane_start = (state_q == T_START);
  assign re_mag     = sim_q[SW-1] ? (SW'(0) - SW'(sim_q)) : SW'(sim_q);
  assign im_mag     = sre_q[SW-1] ? (SW'(0) - SW'(sre_q)) : SW'(sre_q);

  always_comb begin
    re_op.divide = integrate_mode_q;
    re_op.zero   = !in_band_q || omega_zero;
    re_op.neg    = sim_q[SW-1] ^ !integrate_mode_q;
    re_op.mag    = re_mag;
    re_op.taper  = lower_q || upper_q;
    re_op.weight = lower_q ? rd_lo : rd_up;
    im_op        = re_op;
    im_op.neg    = sre_q[SW-1] ^ integrate_mode_q;
    im_op.mag    = im_mag;
  end

  sdi_lane #(
    .OMEGA_W (OMEGA_W)
  ) u_re_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .op_i    (re_op),
    .omega_i (omega_q),
    .ack_i   (out_load),
    .done_o  (re_done),
    .res_o   (re_res)
  );

  sdi_lane #(
    .OMEGA_W (OMEGA_W)
  ) u_im_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .op_i    (im_op),
    .omega_i (omega_q),
    .ack_i   (out_load),
    .done_o  (im_done),
    .res_o   (im_res)
  );

  // an overflowing quotient skips the divider, so the lanes can finish apart
  assign out_load = (state_q == T_RUN) && re_done && im_done &&
                    (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (proc_fire) begin
          state_d = T_START;
        end
      end
      T_START: state_d = T_RUN;
      T_RUN: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign bin32 = 32'(bin_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.result_re      <= re_res.value;
      out_q.result_im      <= im_res.value;
      out_q.bin_number     <= bin32[sdi_pkg::BIN_NUM_W-1:0];
      out_q.saturated      <= re_res.sat || im_res.sat;
      out_q.divide_by_zero <= dz_q;
      out_q.trace_end      <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_lanes_idle_outside_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != T_RUN) |-> !re_done && !im_done)
    else $error("lane finished outside a bin");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |->
      !out_data_o.saturated && (out_data_o.result_re == '0) && (out_data_o.result_im == '0))
    else $error("divide-by-zero result not forced to zero");

  a_busy_after_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> !in_ready_o)
    else $error("new transaction taken while a bin is in flight");

  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BINS - 1))
    else $error("bin counter out of range");
`endif

endmodule

[test/spectral_derivative_integral_top_test.sv]
module spectral_derivative_integral_top_test;
  import sdi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned IDLE_SETTLE  = 64;
  localparam int unsigned CYCLE_LIMIT  = 4000000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  spectral_derivative_integral_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block's registers and tables
  bit                  integrate_q  = 1'b0;
  int unsigned         cut_lo       = 0;
  int unsigned         pass_lo      = 0;
  int unsigned         pass_hi      = 4096;
  int unsigned         cut_hi       = 4096;
  logic [31:0]         omega_step_q = '0;
  int unsigned         bin_count    = 0;
  logic [WEIGHT_W-1:0] lower_taper [TAPER_DEPTH_DEF];
  logic [WEIGHT_W-1:0] upper_taper [TAPER_DEPTH_DEF];

  out_item_t   pending_bins [$];
  int unsigned failures   = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  function automatic longint clip_result(input bit neg, input logic [127:0] mag, inout bit sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        mag = 128'h8000_0000;
      end
      return -longint'(mag[63:0]);
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      mag = 128'h7FFF_FFFF;
    end
    return longint'(mag[63:0]);
  endfunction

  // round(s * omega / 2^20)
  function automatic longint times_omega(input longint s, input logic [63:0] omega,
                                         inout bit sat);
    logic [127:0] mag;
    bit           neg;
    neg = s < 0;
    mag = neg ? 128'(-s) : 128'(s);
    mag = (mag * omega + (128'd1 << 19)) >> FRAC_W;
    return clip_result(neg, mag, sat);
  endfunction

  // round(s * 2^20 / omega)
  function automatic longint over_omega(input longint s, input logic [63:0] omega,
                                        inout bit sat);
    logic [127:0] mag;
    bit           neg;
    neg = s < 0;
    mag = neg ? 128'(-s) : 128'(s);
    mag = (2 * (mag << FRAC_W) + omega) / (2 * 128'(omega));
    return clip_result(neg, mag, sat);
  endfunction

  function automatic longint weigh(input longint v, input logic [WEIGHT_W-1:0] w);
    logic [63:0] mag;
    bit          neg;
    neg = v < 0;
    mag = neg ? 64'(-v) : 64'(v);
    mag = (mag * w + (64'd1 << (TAPER_FRAC_W - 1))) >> TAPER_FRAC_W;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit transform_bin(input in_item_t item, output out_item_t res);
    int unsigned         bin, k;
    logic [63:0]         omega;
    longint              sr, si, re, im;
    bit                  sat, dz;
    logic [WEIGHT_W-1:0] w;
    res = '0;
    re  = 0;
    im  = 0;
    sat = 1'b0;
    dz  = 1'b0;
    w   = (item.taper_weight > WEIGHT_ONE) ? WEIGHT_ONE : item.taper_weight;
    if (item.command == CMD_WR_LOWER) begin
      lower_taper[item.taper_addr] = w;
      return 1'b0;
    end
    if (item.command == CMD_WR_UPPER) begin
      upper_taper[item.taper_addr] = w;
      return 1'b0;
    end
    if (item.command != CMD_PROCESS) return 1'b0;
    bin = bin_count;
    if (bin >= cut_lo && bin < cut_hi) begin
      sr    = longint'($signed(item.sample_re));
      si    = longint'($signed(item.sample_im));
      omega = 64'(bin) * 64'(omega_step_q);
      if (omega == 0) begin
        dz = integrate_q;
      end else if (integrate_q) begin
        re = over_omega(si, omega, sat);
        im = over_omega(-sr, omega, sat);
      end else begin
        re = times_omega(-si, omega, sat);
        im = times_omega(sr, omega, sat);
      end
      if (bin < pass_lo) begin
        k = bin - cut_lo;
        if (k >= TAPER_DEPTH_DEF) k = TAPER_DEPTH_DEF - 1;
        re = weigh(re, lower_taper[k]);
        im = weigh(im, lower_taper[k]);
      end else if (bin >= pass_hi) begin
        k = cut_hi - 1 - bin;
        if (k >= TAPER_DEPTH_DEF) k = TAPER_DEPTH_DEF - 1;
        re = weigh(re, upper_taper[k]);
        im = weigh(im, upper_taper[k]);
      end
    end
    res.result_re      = re[RESULT_W-1:0];
    res.result_im      = im[RESULT_W-1:0];
    res.bin_number     = bin[BIN_NUM_W-1:0];
    res.saturated      = sat;
    res.divide_by_zero = dz;
    res.trace_end      = item.last_bin;
    bin_count = (item.last_bin || bin + 1 >= MAX_BINS_DEF) ? 0 : bin + 1;
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_INTEGRATE_MODE: integrate_q  = value[0];
      CFG_LOW_CUT_BIN:    cut_lo       = value[BIN_REG_W-1:0];
      CFG_LOW_PASS_BIN:   pass_lo      = value[BIN_REG_W-1:0];
      CFG_HIGH_PASS_BIN:  pass_hi      = value[BIN_REG_W-1:0];
      CFG_HIGH_CUT_BIN:   cut_hi       = value[BIN_REG_W-1:0];
      CFG_OMEGA_STEP:     omega_step_q = value[OMEGA_STEP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    out_item_t want, got, next_result;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (pending_bins.size() == 0) begin
          $error("result transaction with no bin pending");
          failures++;
        end else begin
          want = pending_bins.pop_front();
          check_field("result_re", $signed(want.result_re), $signed(got.result_re));
          check_field("result_im", $signed(want.result_im), $signed(got.result_im));
          check_field("bin_number", want.bin_number, got.bin_number);
          check_field("saturated", want.saturated, got.saturated);
          check_field("divide_by_zero", want.divide_by_zero, got.divide_by_zero);
          check_field("trace_end", want.trace_end, got.trace_end);
        end
      end
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        if (transform_bin(in_data_i, next_result)) pending_bins.push_back(next_result);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= stall_left[2];
    endcase
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_item_t process_bin(input logic signed [SAMPLE_WIDTH-1:0] re, im,
                                           input bit last);
    in_item_t item;
    item.command      = CMD_PROCESS;
    item.sample_re    = re;
    item.sample_im    = im;
    item.taper_addr   = TADDR_W'($urandom);
    item.taper_weight = WEIGHT_W'($urandom);
    item.last_bin     = last;
    return item;
  endfunction

  function automatic in_item_t taper_entry(input logic [CMD_W-1:0] cmd,
                                           input logic [TADDR_W-1:0] addr,
                                           input logic [WEIGHT_W-1:0] weight, input bit last);
    in_item_t item;
    item.command      = cmd;
    item.sample_re    = rand_sample();
    item.sample_im    = rand_sample();
    item.taper_addr   = addr;
    item.taper_weight = weight;
    item.last_bin     = last;
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // hold the sender until every result is back and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending_bins.size() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic configure(input bit mode, input int unsigned lc, lp, hp, hc,
                           input logic [OMEGA_STEP_W-1:0] step);
    write_reg(CFG_INTEGRATE_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_LOW_CUT_BIN, CFG_DATA_W'(lc));
    write_reg(CFG_LOW_PASS_BIN, CFG_DATA_W'(lp));
    write_reg(CFG_HIGH_PASS_BIN, CFG_DATA_W'(hp));
    write_reg(CFG_HIGH_CUT_BIN, CFG_DATA_W'(hc));
    write_reg(CFG_OMEGA_STEP, CFG_DATA_W'(step));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_random();
    int unsigned lc, lp, hp, hc;
    logic [OMEGA_STEP_W-1:0] step;
    case ($urandom_range(0, 5))
      0: begin
        lc = $urandom_range(0, 1) * MAX_BINS_DEF;
        lp = $urandom_range(0, 1) * MAX_BINS_DEF;
        hp = $urandom_range(0, 1) * MAX_BINS_DEF;
        hc = $urandom_range(0, 1) * MAX_BINS_DEF;
      end
      1: begin
        lc = $urandom_range(0, 700);
        lp = $urandom_range(0, 700);
        hp = $urandom_range(0, 700);
        hc = $urandom_range(0, 700);
      end
      default: begin
        lc = $urandom_range(0, 40);
        lp = lc + $urandom_range(0, 320);
        hp = lp + $urandom_range(0, 150);
        hc = hp + $urandom_range(0, 320);
      end
    endcase
    case ($urandom_range(0, 5))
      0: step = '0;
      1: step = '1;
      2: step = 1;
      3: step = $urandom;
      4: step = $urandom_range(1 << 16, 1 << 24);
      default: step = $urandom_range(1, 1 << 22);
    endcase
    configure(1'($urandom_range(0, 1)), lc, lp, hp, hc, step);
  endtask

  task automatic load_taper_tables();
    logic [WEIGHT_W-1:0] w;
    for (int a = 0; a < TAPER_DEPTH_DEF; a++) begin
      w = (a == 0) ? '0 : (a == TAPER_DEPTH_DEF - 1) ? '1 : WEIGHT_W'($urandom_range(0, 36000));
      send_item(taper_entry(CMD_WR_LOWER, TADDR_W'(a), w, 1'($urandom_range(0, 1))));
      send_item(taper_entry(CMD_WR_UPPER, TADDR_W'(a), ~w, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_derivative();
    wait_idle();
    configure(1'b0, 0, 0, MAX_BINS_DEF, MAX_BINS_DEF, 32'h0010_0000);
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    send_item(process_bin(0, 0, 1'b1));
    wait_idle();
    configure(1'b0, 0, 0, MAX_BINS_DEF, MAX_BINS_DEF, 32'hFFFF_FFFF);
    send_item(process_bin(1, 1, 1'b0));
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    send_item(process_bin(-1, 1, 1'b1));
  endtask

  task automatic test_integral();
    wait_idle();
    configure(1'b1, 0, 0, MAX_BINS_DEF, MAX_BINS_DEF, 32'h0);
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(5, -5, 1'b1));
    wait_idle();
    configure(1'b1, 0, 0, MAX_BINS_DEF, MAX_BINS_DEF, 32'h1);
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(0, 0, 1'b0));
    send_item(process_bin(1, -1, 1'b1));
    wait_idle();
    configure(1'b1, 0, 0, MAX_BINS_DEF, MAX_BINS_DEF, 32'hFFFF_FFFF);
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    send_item(process_bin(-1, 1, 1'b1));
  endtask

  task automatic test_taper_bands();
    send_item(taper_entry(CMD_WR_LOWER, 0, '0, 1'b0));
    send_item(taper_entry(CMD_WR_LOWER, 1, WEIGHT_ONE, 1'b0));
    send_item(taper_entry(CMD_WR_UPPER, 0, '1, 1'b0));
    wait_idle();
    configure(1'b0, 2, 5, 9, 12, 32'h0040_0000);
    for (int b = 0; b <= 12; b++)
      send_item(process_bin(rand_sample(), rand_sample(), b == 12));
    // lower band overlaps the upper one
    wait_idle();
    configure(1'b1, 3, 8, 5, 7, 32'h0000_8000);
    for (int b = 0; b <= 7; b++)
      send_item(process_bin(rand_sample(), rand_sample(), b == 7));
  endtask

  task automatic test_ignored_commands();
    wait_idle();
    configure(1'b0, 0, 0, MAX_BINS_DEF, MAX_BINS_DEF, 32'h0008_0000);
    send_item(process_bin(SAMPLE_MAX, 3, 1'b0));
    send_item(taper_entry(CMD_UNUSED, '1, '1, 1'b1));
    send_item(taper_entry(CMD_WR_UPPER, '1, 16'h8001, 1'b1));
    send_item(process_bin(-3, SAMPLE_MIN, 1'b1));
  endtask

  task automatic test_random();
    int unsigned sent, goal, trace_len, roll;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      configure_random();
      goal = sent + $urandom_range(120, 300);
      while (sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: trace_len = $urandom_range(1, 40);
          6, 7, 8:          trace_len = $urandom_range(41, 300);
          default:          trace_len = $urandom_range(301, 700);
        endcase
        for (int unsigned b = 0; b < trace_len; b++) begin
          roll = $urandom_range(0, 99);
          if (roll < 5) begin
            send_item(taper_entry($urandom_range(0, 1) ? CMD_WR_UPPER : CMD_WR_LOWER,
                                  TADDR_W'($urandom), WEIGHT_W'($urandom),
                                  1'($urandom_range(0, 1))));
            sent++;
          end else if (roll < 7) begin
            send_item(taper_entry(CMD_UNUSED, TADDR_W'($urandom), WEIGHT_W'($urandom),
                                  1'($urandom_range(0, 1))));
          end else if (roll == 99) begin
            wait_idle();
          end
          // early last_bin breaks the trace now and then
          send_item(process_bin(rand_sample(), rand_sample(), b == trace_len - 1 || roll == 98));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    load_taper_tables();
    test_derivative();
    test_integral();
    test_taper_bands();
    test_ignored_commands();
    test_random();
    wait_idle();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sdi_pkg.sv
rtl/sdi_ram.sv
rtl/sdi_lane.sv
rtl/spectral_derivative_integral_top.sv
test/spectral_derivative_integral_top_test.sv
